// File: hw/rtl/md5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_pkg
// Shared constants, types and round tables for the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;

    typedef enum logic [1:0] {
        SRC_MSG  = 2'd0,
        SRC_PAD  = 2'd1,
        SRC_ZERO = 2'd2,
        SRC_LEN  = 2'd3
    } byte_src_t;

    typedef struct packed {
        logic      put;
        byte_src_t src;
        logic      snap_len;
        logic      comp_start;
        logic      comp_step;
        logic      comp_fold;
        logic      clear;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } md5_stat_t;

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            case (r)
                6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
                6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
                6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
                6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
                6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
                6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
                6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
                6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
                6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
                6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
                6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
                6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
                default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    function automatic logic [4:0] round_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            case ({r[5:4], r[1:0]})
                4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
                4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
                4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
                4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // message word index for round r
    function automatic logic [3:0] round_g(input logic [5:0] r);
        logic [3:0] g;
        begin
            case (r[5:4])
                2'd0: g = r[3:0];
                2'd1: g = 4'(5 * r[3:0] + 1);
                2'd2: g = 4'(3 * r[3:0] + 5);
                default: g = 4'(7 * r[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/md5_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_ram
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: hw/rtl/md5_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_datapath
// Block buffer, bit count, chaining state and the shared round unit.
// ----------------------------------------------------------------------------
module md5_datapath
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire md5_cmd_t    cmd,
    input  wire logic [7:0]  msg_byte,
    input  wire logic [1:0]  sel_word,
    output md5_stat_t        stat,
    output logic      [31:0] word_out
);
    logic [63:0] cnt_reg, cnt_next;
    logic [63:0] len_reg;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  rnd_reg;
    logic [23:0] part_reg;
    logic [7:0]  wbyte;
    logic [2:0]  len_sel;
    logic [31:0] ram_wdata, ram_rdata, f, t, tr;
    logic [3:0]  ram_raddr;
    logic [5:0]  fill;
    logic [5:0]  rnd_nxt;

    assign fill = cnt_reg[8:3];
    assign len_sel = fill[2:0];
    assign stat.fill = fill;
    assign stat.round_last = (rnd_reg == 6'd63);

    always_comb
    begin
        case (cmd.src)
            SRC_MSG:  wbyte = msg_byte;
            SRC_PAD:  wbyte = PAD_BYTE;
            SRC_ZERO: wbyte = 8'h00;
            SRC_LEN:  wbyte = len_reg[{len_sel, 3'b000} +: 8];
            default:  wbyte = 8'h00;
        endcase
    end

    assign ram_wdata = {wbyte, part_reg};
    assign cnt_next = cnt_reg + 64'd8;

    // read address runs one round ahead of the round counter
    assign rnd_nxt = cmd.comp_start ? 6'd0 : rnd_reg + 6'd1;
    assign ram_raddr = round_g(cmd.comp_start || cmd.comp_step ? rnd_nxt : rnd_reg);

    md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
        .clk   (clk),
        .we    (cmd.put && fill[1:0] == 2'd3),
        .waddr (fill[5:2]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
    end

    assign t = a_reg + f + ram_rdata + round_k(rnd_reg);
    assign tr = (t << round_s(rnd_reg)) | (t >> (6'd32 - {1'b0, round_s(rnd_reg)}));

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            part_reg <= {wbyte, part_reg[23:8]};
        end
        if (cmd.snap_len)
        begin
            len_reg <= cnt_reg;
        end
        if (cmd.comp_start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
        end
        else if (cmd.comp_step)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + tr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rnd_reg <= '0;
            h_reg[0] <= IV_A;
            h_reg[1] <= IV_B;
            h_reg[2] <= IV_C;
            h_reg[3] <= IV_D;
        end
        else
        begin
            if (cmd.comp_start || cmd.comp_step)
            begin
                rnd_reg <= rnd_nxt;
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
                h_reg[0] <= IV_A;
                h_reg[1] <= IV_B;
                h_reg[2] <= IV_C;
                h_reg[3] <= IV_D;
            end
            else
            begin
                if (cmd.put)
                begin
                    cnt_reg <= cnt_next;
                end
                if (cmd.comp_fold)
                begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                end
            end
        end
    end

    assign word_out = h_reg[sel_word];
endmodule
`default_nettype wire

// File: hw/rtl/md5_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_ctrl
// Sequencer: byte intake, padding, compression rounds and digest output.
// ----------------------------------------------------------------------------
module md5_ctrl
    import md5_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_present,
    input  wire logic       in_last,
    output logic            in_ready,
    input  wire logic       out_ready,
    output logic            out_valid,
    output logic      [1:0] out_idx,
    input  wire md5_stat_t  stat,
    output md5_cmd_t        cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_PAD, ST_FILL, ST_START, ST_ROUND, ST_FOLD, ST_OUT
    } state_t;

    state_t     state_reg;
    logic       fin_reg;
    logic [1:0] idx_reg;
    logic       take, put_msg, full;
    // pad byte written; length allowed in this block; length written
    logic       pad_done_reg, len_ok_reg, len_done_reg;

    assign in_ready  = (state_reg == ST_IDLE);
    assign take      = in_valid && in_ready;
    assign put_msg   = take && in_present;
    assign full      = (stat.fill == 6'd63);
    assign out_valid = (state_reg == ST_OUT);
    assign out_idx   = idx_reg;

    always_comb
    begin
        cmd = '0;
        cmd.src = SRC_MSG;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.put = put_msg;
            end
            ST_PAD:
            begin
                cmd.put = 1'b1;
                cmd.src = SRC_PAD;
                cmd.snap_len = 1'b1;
            end
            ST_FILL:
            begin
                cmd.put = 1'b1;
                cmd.src = (stat.fill[5:3] == 3'd7 && len_ok_reg) ? SRC_LEN : SRC_ZERO;
            end
            ST_START: cmd.comp_start = 1'b1;
            ST_ROUND: cmd.comp_step = 1'b1;
            ST_FOLD:  cmd.comp_fold = 1'b1;
            ST_OUT:   cmd.clear = out_ready && idx_reg == 2'd3;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fin_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        fin_reg <= in_last;
                        if (put_msg && full)
                        begin
                            state_reg <= ST_START;
                        end
                        else if (in_last)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    state_reg <= full ? ST_START : ST_FILL;
                end
                ST_FILL:
                begin
                    if (full)
                    begin
                        state_reg <= ST_START;
                    end
                end
                ST_START: state_reg <= ST_ROUND;
                ST_ROUND:
                begin
                    if (stat.round_last)
                    begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD:
                begin
                    if (!fin_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (len_done_reg)
                    begin
                        state_reg <= ST_OUT;
                        idx_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= pad_done_reg ? ST_FILL : ST_PAD;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                            fin_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // length goes in the pad block if the pad sits below the length field,
    // else in the block after it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_done_reg <= 1'b0;
            len_ok_reg <= 1'b0;
            len_done_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_PAD)
            begin
                pad_done_reg <= 1'b1;
                len_ok_reg <= (stat.fill < LEN_OFFSET);
            end
            if (state_reg == ST_FOLD && pad_done_reg)
            begin
                len_ok_reg <= 1'b1;
            end
            if (state_reg == ST_FILL && full && len_ok_reg)
            begin
                len_done_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && out_ready && idx_reg == 2'd3)
            begin
                pad_done_reg <= 1'b0;
                len_ok_reg <= 1'b0;
                len_done_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/md5_hash_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// md5_hash_engine
// Streaming MD5 digest, one byte per request, digest as four words.
// ----------------------------------------------------------------------------
// A message byte is taken while the engine is idle; the 64th byte of a block
// starts a compression (one shared round unit, 64 rounds plus load and
// fold) during which no request is taken. A closing request pads the block
// one byte per cycle, runs one or two compressions, then presents the digest
// words A..D. The block buffer is a 16 x 32 RAM read once per round.
module md5_hash_engine
    import md5_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tuser,  // [0] byte_present
    input  wire logic        s_axis_tlast,  // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,  // [31:0] digest_word
    output logic      [1:0]  m_axis_tuser,  // [1:0] word_index
    output logic             m_axis_tlast   // digest_last
);
    md5_cmd_t   cmd;
    md5_stat_t  stat;
    logic [1:0] idx;

    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_present (s_axis_tuser),
        .in_last    (s_axis_tlast),
        .in_ready   (s_axis_tready),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_idx    (idx),
        .stat       (stat),
        .cmd        (cmd)
    );

    md5_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .msg_byte (s_axis_tdata),
        .sel_word (idx),
        .stat     (stat),
        .word_out (m_axis_tdata)
    );

    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == 2'd3);

    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid &&
        m_axis_tuser == $past(m_axis_tuser) + 2'd1) else $error("digest word skipped");
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> m_axis_tuser == 2'd0) else $error("digest not from A");
endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the MD5 engine: byte requests (with idle and closing requests) are
// folded into a local MD5 digest predictor; digest words are compared in order.
// ----------------------------------------------------------------------------
module tb;
    import md5_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       close;
    } md5_req_t;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  idx;
        logic        fin;
    } digest_word_t;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    logic [31:0]  chain_st[4];
    logic [7:0]   blk_buf[64];
    logic [63:0]  msg_bits;
    digest_word_t digest_q[$];
    int           n_errors = 0;
    int           n_cycles = 0;
    bit           stall_free = 1'b0;

    md5_hash_engine i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    task automatic chain_init();
        chain_st[0] = IV_A;
        chain_st[1] = IV_B;
        chain_st[2] = IV_C;
        chain_st[3] = IV_D;
        msg_bits = '0;
    endtask

    task automatic fold_block();
        logic [31:0] w[16];
        logic [31:0] a, b, c, d, f, t;
        int g;
        int sh;
        int sa[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        logic [31:0] kc;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i+3], blk_buf[4*i+2], blk_buf[4*i+1], blk_buf[4*i]};
        a = chain_st[0]; b = chain_st[1]; c = chain_st[2]; d = chain_st[3];
        for (int r = 0; r < 64; r++) begin
            case (r / 16)
                0: begin f = (b & c) | (~b & d); g = r; end
                1: begin f = (b & d) | (c & ~d); g = (5 * r + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * r + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * r) % 16; end
            endcase
            kc = 32'(longint'($floor((($sin(r + 1.0) < 0) ? -$sin(r + 1.0)
                 : $sin(r + 1.0)) * 4294967296.0)));
            sh = sa[(r / 16) * 4 + r % 4];
            t = a + f + w[g] + kc;
            t = b + rotl(t, sh);
            a = d; d = c; c = b; b = t;
        end
        chain_st[0] += a; chain_st[1] += b; chain_st[2] += c; chain_st[3] += d;
    endtask

    task automatic append_byte(input logic [7:0] v);
        int pos;
        pos = int'(msg_bits[8:3]);
        blk_buf[pos] = v;
        msg_bits += 64'd8;
        if (pos == 63) fold_block();
    endtask

    task automatic predict_digest(input md5_req_t rq);
        logic [63:0] len;
        if (rq.present) append_byte(rq.data);
        if (rq.close) begin
            len = msg_bits;
            append_byte(PAD_BYTE);
            while (msg_bits[8:3] != LEN_OFFSET) append_byte(8'h00);
            for (int k = 0; k < 8; k++) append_byte(len[8*k +: 8]);
            for (int k = 0; k < 4; k++)
                digest_q.push_back('{chain_st[k], 2'(k), k == 3});
            chain_init();
        end
    endtask

    task automatic send(input md5_req_t rq);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rq.data;
        s_axis_tuser  <= rq.present;
        s_axis_tlast  <= rq.close;
        do @(posedge clk); while (!s_axis_tready);
        predict_digest(rq);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    // directed rows: data, present, close, expected first word (0 = use predictor)
    typedef struct {
        md5_req_t    rq;
        logic [31:0] first_word;
    } stim_row_t;

    stim_row_t stim_tbl[] = '{
        '{'{8'h00, 1'b0, 1'b1}, 32'hd98c1dd4},
        '{'{8'h00, 1'b0, 1'b0}, 32'h0},
        '{'{8'h61, 1'b1, 1'b1}, 32'hb975c10c},
        '{'{8'h61, 1'b1, 1'b0}, 32'h0},
        '{'{8'h62, 1'b1, 1'b0}, 32'h0},
        '{'{8'h63, 1'b1, 1'b0}, 32'h0},
        '{'{8'h00, 1'b0, 1'b1}, 32'h98500190},
        '{'{8'hff, 1'b1, 1'b0}, 32'h0},
        '{'{8'h00, 1'b1, 1'b0}, 32'h0},
        '{'{8'haa, 1'b0, 1'b0}, 32'h0},
        '{'{8'h55, 1'b1, 1'b1}, 32'h0},
        '{'{8'hff, 1'b0, 1'b1}, 32'h0}
    };

    always @(posedge clk) begin
        digest_word_t got, exp_w;
        n_cycles <= n_cycles + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata, m_axis_tuser, m_axis_tlast};
            if (digest_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected digest word %h", got);
            end else begin
                exp_w = digest_q.pop_front();
                if (got !== exp_w) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d",
                            exp_w.word, exp_w.idx, exp_w.fin,
                            got.word, got.idx, got.fin);
                end
            end
        end
        if (n_cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(negedge clk) begin
        if (stall_free || n_cycles % 97 > 40) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 2) != 0);
    end

    task automatic send_message(input int len, input bit noisy);
        md5_req_t rq;
        for (int i = 0; i < len; i++) begin
            rq = '{8'($urandom), 1'b1, 1'b0};
            if (noisy && $urandom_range(0, 15) == 0) rq.present = 1'b0;
            send(rq);
            if ($urandom_range(0, 9) == 0) idle_gap();
        end
        rq = '{8'($urandom), 1'($urandom), 1'b1};
        send(rq);
    endtask

    initial begin
        int sent;
        int len;
        chain_init();
        for (int i = 0; i < 64; i++) blk_buf[i] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (stim_tbl[i]) begin
            if (stim_tbl[i].first_word != 32'h0) begin
                send(stim_tbl[i].rq);
                if (digest_q[digest_q.size() - 4].word != stim_tbl[i].first_word) begin
                    n_errors++;
                    $display("predictor word A %h, table %h",
                        digest_q[digest_q.size() - 4].word, stim_tbl[i].first_word);
                end
            end else begin
                send(stim_tbl[i].rq);
            end
        end
        idle_gap();

        sent = 0;
        while (sent < 500) begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(100, 200);
                1, 2: len = $urandom_range(52, 66);
                default: len = $urandom_range(0, 20);
            endcase
            stall_free = ($urandom_range(0, 4) == 0);
            send_message(len, $urandom_range(0, 3) == 0);
            sent += len + 1;
            idle_gap();
        end
        s_axis_tvalid <= 1'b0;

        while (digest_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
